[sv/gsd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gsd_pkg
// Shared types and constants for the grid second derivative stencil.
// ----------------------------------------------------------------------------
package gsd_pkg;

    // Largest padded plane the delay store is sized for
    localparam int MAX_PADDED_COLS = 64;
    localparam int MAX_PADDED_ROWS = 64;

    // Delay store holds two padded planes
    localparam int STORE_DEPTH = 2 * MAX_PADDED_COLS * MAX_PADDED_ROWS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int OFF_W       = $clog2(STORE_DEPTH + 1);
    localparam int PLANE_W     = $clog2(MAX_PADDED_COLS * MAX_PADDED_ROWS + 1);

    localparam int COL_W   = $clog2(MAX_PADDED_COLS + 1);
    localparam int ROW_W   = $clog2(MAX_PADDED_ROWS + 1);
    localparam int LAYER_W = 17;

    // Register field widths
    localparam int AXIS_W  = 2;
    localparam int ICOL_W  = 6;
    localparam int IROW_W  = 6;
    localparam int ILAY_W  = 16;
    localparam int SCALE_W = 32;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 3;

    localparam int SAMPLE_W = 32;
    localparam int WORD_W   = 2 * SAMPLE_W;

    // Front/back queue
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_SELECT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERIOR_COLS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTERIOR_ROWS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTERIOR_LAYER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_H_SQUARED  = 3'd4;

    typedef enum logic [AXIS_W-1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef struct packed {
        logic [AXIS_W-1:0]  axis_select;
        logic [ICOL_W-1:0]  interior_cols;
        logic [IROW_W-1:0]  interior_rows;
        logic [ILAY_W-1:0]  interior_layers;
        logic [SCALE_W-1:0] inv_h_squared;
    } gsd_cfg_t;

    // One stencil, real part in the low half of each word
    typedef struct packed {
        logic [WORD_W-1:0] prv;
        logic [WORD_W-1:0] cen;
        logic [WORD_W-1:0] cur;
        logic              last;
    } gsd_item_t;

endpackage : gsd_pkg
`default_nettype wire

[sv/gsd_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gsd_front
// Grid position counters, stencil classification and the plane delay store.
// ----------------------------------------------------------------------------
module gsd_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire gsd_pkg::gsd_cfg_t          cfg,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [gsd_pkg::WORD_W-1:0] s_tdata,
    input  wire logic [gsd_pkg::Q_CNT_W-1:0] q_count,
    output logic                            push,
    output gsd_pkg::gsd_item_t              push_item
);
    import gsd_pkg::*;

    logic [WORD_W-1:0]  store_mem [STORE_DEPTH];

    logic [COL_W-1:0]   c_reg, c_next, c_inc, pc;
    logic [ROW_W-1:0]   r_reg, r_next, r_inc, pr;
    logic [LAYER_W-1:0] l_reg, l_next, l_inc, pl;
    logic [ADDR_W-1:0]  ptr_reg, ptr_next;
    logic [OFF_W-1:0]   fill_reg, fill_next;

    logic [PLANE_W-1:0] plane;
    logic [OFF_W-1:0]   step, step2;
    logic [ADDR_W-1:0]  addr_cen, addr_prv;
    logic               emit, last, accept;

    logic               b_valid_reg;
    logic               b_last_reg, b_cen_ok_reg, b_prv_ok_reg;
    logic [WORD_W-1:0]  b_cur_reg, rd_cen_reg, rd_prv_reg;

    // circular address ptr - off
    function automatic logic [ADDR_W-1:0] back_addr(input logic [ADDR_W-1:0] ptr,
                                                    input logic [OFF_W-1:0] off);
        logic [OFF_W-1:0] p;
        p = OFF_W'(ptr);
        if (p >= off)
            back_addr = ADDR_W'(p - off);
        else
            back_addr = ADDR_W'(p + OFF_W'(STORE_DEPTH) - off);
    endfunction

    // Padded sizes: zero counts as one, plane limited to the store size
    always_comb
    begin
        if (cfg.interior_cols == '0)
            pc = COL_W'(3);
        else if (32'(cfg.interior_cols) > 32'(MAX_PADDED_COLS - 2))
            pc = COL_W'(MAX_PADDED_COLS);
        else
            pc = COL_W'(cfg.interior_cols) + COL_W'(2);

        if (cfg.interior_rows == '0)
            pr = ROW_W'(3);
        else if (32'(cfg.interior_rows) > 32'(MAX_PADDED_ROWS - 2))
            pr = ROW_W'(MAX_PADDED_ROWS);
        else
            pr = ROW_W'(cfg.interior_rows) + ROW_W'(2);

        if (cfg.interior_layers == '0)
            pl = LAYER_W'(3);
        else
            pl = LAYER_W'(cfg.interior_layers) + LAYER_W'(2);

        plane = PLANE_W'(pc * pr);
    end

    // Classification against the selected axis
    always_comb
    begin
        emit = 1'b0;
        last = 1'b0;
        step = OFF_W'(1);
        case (cfg.axis_select)
            AXIS_X:
            begin
                step = OFF_W'(1);
                emit = c_reg >= COL_W'(2) && c_reg <= pc - COL_W'(1)
                    && r_reg >= ROW_W'(1) && r_reg <= pr - ROW_W'(2)
                    && l_reg >= LAYER_W'(1) && l_reg <= pl - LAYER_W'(2);
                last = c_reg == pc - COL_W'(1) && r_reg == pr - ROW_W'(2)
                    && l_reg == pl - LAYER_W'(2);
            end
            AXIS_Y:
            begin
                step = OFF_W'(pc);
                emit = c_reg >= COL_W'(1) && c_reg <= pc - COL_W'(2)
                    && r_reg >= ROW_W'(2) && r_reg <= pr - ROW_W'(1)
                    && l_reg >= LAYER_W'(1) && l_reg <= pl - LAYER_W'(2);
                last = c_reg == pc - COL_W'(2) && r_reg == pr - ROW_W'(1)
                    && l_reg == pl - LAYER_W'(2);
            end
            AXIS_Z:
            begin
                step = OFF_W'(plane);
                emit = c_reg >= COL_W'(1) && c_reg <= pc - COL_W'(2)
                    && r_reg >= ROW_W'(1) && r_reg <= pr - ROW_W'(2)
                    && l_reg >= LAYER_W'(2) && l_reg <= pl - LAYER_W'(1);
                last = c_reg == pc - COL_W'(2) && r_reg == pr - ROW_W'(2)
                    && l_reg == pl - LAYER_W'(1);
            end
            default:
            begin
                emit = 1'b0;
                last = 1'b0;
            end
        endcase
        step2    = step << 1;
        addr_cen = back_addr(ptr_reg, step);
        addr_prv = back_addr(ptr_reg, step2);
    end

    // Raster counters; each wraps once its increment reaches the padded size
    always_comb
    begin
        c_inc  = c_reg + COL_W'(1);
        r_inc  = r_reg + ROW_W'(1);
        l_inc  = l_reg + LAYER_W'(1);
        c_next = c_inc;
        r_next = r_reg;
        l_next = l_reg;
        if (c_inc >= pc)
        begin
            c_next = '0;
            r_next = r_inc;
            if (r_inc >= pr)
            begin
                r_next = '0;
                l_next = (l_inc >= pl) ? '0 : l_inc;
            end
        end
        ptr_next  = (32'(ptr_reg) == STORE_DEPTH - 1) ? '0 : ptr_reg + ADDR_W'(1);
        fill_next = (32'(fill_reg) == STORE_DEPTH) ? fill_reg : fill_reg + OFF_W'(1);
    end

    // Room for this word and the one already on its way to the queue
    assign s_tready = ({1'b0, q_count} + (Q_CNT_W + 1)'(b_valid_reg))
                      < (Q_CNT_W + 1)'(Q_DEPTH);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_reg       <= '0;
            r_reg       <= '0;
            l_reg       <= '0;
            ptr_reg     <= '0;
            fill_reg    <= '0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= accept && emit;
            if (accept)
            begin
                c_reg    <= c_next;
                r_reg    <= r_next;
                l_reg    <= l_next;
                ptr_reg  <= ptr_next;
                fill_reg <= fill_next;
            end
        end
    end

    // Store: one write, two reads; a read sees the old word on a same-slot write
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            store_mem[ptr_reg] <= s_tdata;
            rd_cen_reg         <= store_mem[addr_cen];
            rd_prv_reg         <= store_mem[addr_prv];
        end
    end

    // Slots not yet written since reset read as zero
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_cur_reg    <= s_tdata;
            b_last_reg   <= last;
            b_cen_ok_reg <= fill_reg >= step;
            b_prv_ok_reg <= fill_reg >= step2;
        end
    end

    assign push           = b_valid_reg;
    assign push_item.prv  = b_prv_ok_reg ? rd_prv_reg : '0;
    assign push_item.cen  = b_cen_ok_reg ? rd_cen_reg : '0;
    assign push_item.cur  = b_cur_reg;
    assign push_item.last = b_last_reg;

endmodule : gsd_front
`default_nettype wire

[sv/gsd_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gsd_queue
// Short FIFO of stencils between the front and the arithmetic back end.
// ----------------------------------------------------------------------------
module gsd_queue (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    input  wire gsd_pkg::gsd_item_t          push_item,
    input  wire logic                        pop,
    output gsd_pkg::gsd_item_t               head_item,
    output logic                             not_empty,
    output logic [gsd_pkg::Q_CNT_W-1:0]      count
);
    import gsd_pkg::*;

    gsd_item_t            q_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg, count_next;
    logic                 do_pop;

    // Front only pushes when there is room
    assign do_pop = pop && (count_reg != '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
            count_next = count_reg + Q_CNT_W'(1);
        else if (!push && do_pop)
            count_next = count_reg - Q_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (32'(wr_ptr_reg) == Q_DEPTH - 1) ? '0
                              : wr_ptr_reg + Q_PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (32'(rd_ptr_reg) == Q_DEPTH - 1) ? '0
                              : rd_ptr_reg + Q_PTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= push_item;
    end

    assign head_item = q_mem[rd_ptr_reg];
    assign not_empty = count_reg != '0;
    assign count     = count_reg;

endmodule : gsd_queue
`default_nettype wire

[sv/gsd_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gsd_back
// Stencil sum, Q16.16 scaling with rounding, saturation, output register.
// ----------------------------------------------------------------------------
module gsd_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [gsd_pkg::SCALE_W-1:0]  inv_h_squared,
    input  wire gsd_pkg::gsd_item_t           head_item,
    input  wire logic                         not_empty,
    output logic                              pop,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [gsd_pkg::WORD_W-1:0]        m_tdata,
    output logic                              m_tuser,
    output logic                              m_tlast
);
    import gsd_pkg::*;

    localparam int SUM_W  = SAMPLE_W + 3;
    localparam int HALF_W = SCALE_W / 2;
    localparam int PROD_W = SUM_W + HALF_W + 1;
    localparam int TOT_W  = PROD_W + HALF_W + 1;
    localparam int RES_W  = TOT_W - HALF_W;

    logic                      en;
    logic                      v1_reg, v2_reg, v3_reg;
    logic                      last1_reg, last2_reg, last3_reg;
    logic signed [SUM_W-1:0]   s_re_reg, s_im_reg;
    logic signed [PROD_W-1:0]  ph_re_reg, pl_re_reg, ph_im_reg, pl_im_reg;
    logic signed [HALF_W:0]    k_hi, k_lo;
    logic [SAMPLE_W:0]         res_re, res_im;
    logic [SAMPLE_W-1:0]       out_re_reg, out_im_reg;
    logic                      sat_reg;

    function automatic logic signed [SUM_W-1:0] stencil(input logic [SAMPLE_W-1:0] p,
                                                        input logic [SAMPLE_W-1:0] c,
                                                        input logic [SAMPLE_W-1:0] n);
        logic signed [SUM_W-1:0] ps, cs, ns;
        ps = SUM_W'($signed(p));
        cs = SUM_W'($signed(c));
        ns = SUM_W'($signed(n));
        stencil = ps - (cs <<< 1) + ns;
    endfunction

    // {saturated, value}: (s*k + 2^15) >> 16, round half up, clipped to 32 bits
    function automatic logic [SAMPLE_W:0] round_sat(input logic signed [PROD_W-1:0] ph,
                                                    input logic signed [PROD_W-1:0] pl);
        logic signed [TOT_W-1:0] tot;
        logic signed [RES_W-1:0] r;
        logic                    pos_ovf, neg_ovf;
        tot = (TOT_W'(ph) <<< HALF_W) + TOT_W'(pl)
            + (TOT_W'(1) <<< (HALF_W - 1));
        r   = tot[TOT_W-1:HALF_W];
        pos_ovf = !r[RES_W-1] && (|r[RES_W-2:SAMPLE_W-1]);
        neg_ovf = r[RES_W-1] && !(&r[RES_W-2:SAMPLE_W-1]);
        if (pos_ovf)
            round_sat = {1'b1, 1'b0, {(SAMPLE_W-1){1'b1}}};
        else if (neg_ovf)
            round_sat = {1'b1, 1'b1, {(SAMPLE_W-1){1'b0}}};
        else
            round_sat = {1'b0, r[SAMPLE_W-1:0]};
    endfunction

    // All stages move together whenever the output register can take a word
    assign en  = !v3_reg || m_tready;
    assign pop = en && not_empty;

    assign k_hi = {1'b0, inv_h_squared[SCALE_W-1:HALF_W]};
    assign k_lo = {1'b0, inv_h_squared[HALF_W-1:0]};

    assign res_re = round_sat(ph_re_reg, pl_re_reg);
    assign res_im = round_sat(ph_im_reg, pl_im_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= not_empty;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_re_reg   <= stencil(head_item.prv[SAMPLE_W-1:0],
                                  head_item.cen[SAMPLE_W-1:0],
                                  head_item.cur[SAMPLE_W-1:0]);
            s_im_reg   <= stencil(head_item.prv[WORD_W-1:SAMPLE_W],
                                  head_item.cen[WORD_W-1:SAMPLE_W],
                                  head_item.cur[WORD_W-1:SAMPLE_W]);
            last1_reg  <= head_item.last;

            ph_re_reg  <= s_re_reg * k_hi;
            pl_re_reg  <= s_re_reg * k_lo;
            ph_im_reg  <= s_im_reg * k_hi;
            pl_im_reg  <= s_im_reg * k_lo;
            last2_reg  <= last1_reg;

            out_re_reg <= res_re[SAMPLE_W-1:0];
            out_im_reg <= res_im[SAMPLE_W-1:0];
            sat_reg    <= res_re[SAMPLE_W] || res_im[SAMPLE_W];
            last3_reg  <= last2_reg;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = {out_im_reg, out_re_reg};
    assign m_tuser  = sat_reg;
    assign m_tlast  = last3_reg;

endmodule : gsd_back
`default_nettype wire

[sv/grid_second_derivative_stencil.sv]
`default_nettype none
// An accepted input word reaches the master side through the store read, the queue,
//   the stencil sum, the multiply and round/saturate into the output register.
// Throughput: one word per cycle, set by the delay store's one write and two reads per
//   cycle and the single multiply stage, until output stalls fill the 4-entry queue.
// Reset: position counters, store pointer, fill count and all valids clear; registers
//   take their defaults. The store itself is not swept: unwritten slots read as zero.
// ----------------------------------------------------------------------------
// grid_second_derivative_stencil
// Three-point second derivative along x, y or z of a zero-padded complex 3D
// grid streamed in raster order, scaled by 1/h^2 in Q16.16.
// ----------------------------------------------------------------------------
module grid_second_derivative_stencil (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration write port
    input  wire logic                          cfg_write_en,
    input  wire logic [gsd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [gsd_pkg::CFG_W-1:0]     cfg_data,
    // sample stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [63:0]                   s_tdata,  // sample_re, sample_im
    // result stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [63:0]                        m_tdata,  // deriv_re, deriv_im
    output logic                               m_tuser,  // saturated
    output logic                               m_tlast   // last_point
);
    import gsd_pkg::*;

    gsd_cfg_t            cfg_reg;
    logic                push, pop, not_empty;
    gsd_item_t           push_item, head_item;
    logic [Q_CNT_W-1:0]  q_count;

    // Register file; unknown indexes are dropped, fields keep their low bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.axis_select     <= AXIS_X;
            cfg_reg.interior_cols   <= ICOL_W'(62);
            cfg_reg.interior_rows   <= IROW_W'(62);
            cfg_reg.interior_layers <= ILAY_W'(1);
            cfg_reg.inv_h_squared   <= SCALE_W'(65536);
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_AXIS_SELECT:    cfg_reg.axis_select     <= cfg_data[AXIS_W-1:0];
                REG_INTERIOR_COLS:  cfg_reg.interior_cols   <= cfg_data[ICOL_W-1:0];
                REG_INTERIOR_ROWS:  cfg_reg.interior_rows   <= cfg_data[IROW_W-1:0];
                REG_INTERIOR_LAYER: cfg_reg.interior_layers <= cfg_data[ILAY_W-1:0];
                REG_INV_H_SQUARED:  cfg_reg.inv_h_squared   <= cfg_data[SCALE_W-1:0];
                default:            cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // Front: counters, classify, store write and neighbor reads
    gsd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_count   (q_count),
        .push      (push),
        .push_item (push_item)
    );

    // Stencils waiting for the arithmetic pipe
    gsd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .not_empty (not_empty),
        .count     (q_count)
    );

    // Back: sum, scale, round, saturate, output register
    gsd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .inv_h_squared (cfg_reg.inv_h_squared),
        .head_item     (head_item),
        .not_empty     (not_empty),
        .pop           (pop),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast)
    );

endmodule : grid_second_derivative_stencil
`default_nettype wire

[tb/grid_second_derivative_stencil_tb.sv]
// ----------------------------------------------------------------------------
// grid_second_derivative_stencil_tb
// Streams padded complex grids through the stencil, mirrors the block's
// position counters, two-plane delay store and Q16.16 scaling word by word,
// and checks every derivative word against the mirrored value. Covers all
// three axes plus the unused axis code, clamped and zero sizes, resizes
// mid-grid, and random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module grid_second_derivative_stencil_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gsd_pkg::*;

    // Axis code that selects no direction: samples are stored, nothing comes out
    localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd3;

    // Cycles to let the pipeline drain before touching the registers
    localparam int DRAIN_CYCLES = 8;
    // Bound on waiting for outstanding words between and after phases
    localparam int PATIENCE = 4000;
    localparam int TARGET_SAMPLES = 1050;

    localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN = 32'h8000_0000;

    // One expected derivative word
    typedef struct {
        logic [31:0] re;
        logic [31:0] im;
        logic        clipped;
        logic        grid_end;
    } deriv_word_t;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT hookup
    // ------------------------------------------------------------------------
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [63:0]          s_tdata = '0;   // sample_re, sample_im
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [63:0]          m_tdata;        // deriv_re, deriv_im
    logic                 m_tuser;        // saturated
    logic                 m_tlast;        // last_point

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    grid_second_derivative_stencil u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast)
    );

    // ------------------------------------------------------------------------
    // Mirror of the block: registers, delay store, raster position
    // ------------------------------------------------------------------------
    logic [AXIS_W-1:0]  cfg_axis   = AXIS_X;
    logic [ICOL_W-1:0]  cfg_cols   = 6'd62;
    logic [IROW_W-1:0]  cfg_rows   = 6'd62;
    logic [ILAY_W-1:0]  cfg_layers = 16'd1;
    logic [SCALE_W-1:0] cfg_scale  = 32'd65536;

    logic [63:0] grid_store [0:STORE_DEPTH-1];
    int          store_ptr = 0;
    int          pos_col   = 0;
    int          pos_row   = 0;
    int          pos_layer = 0;

    deriv_word_t pending_derivs [$];

    // stimulus side
    logic [63:0] sample_backlog [$];
    int          samples_queued = 0;
    int          samples_taken  = 0;
    bit          quiet_pace     = 1'b0;   // phase runs with no gaps and no stalls

    // handshake seen at the last rising edge, read by the falling-edge drivers
    bit in_fire  = 1'b0;
    bit out_fire = 1'b0;
    int gap_left   = 0;
    int stall_left = 0;

    // bookkeeping
    int mismatches   = 0;
    int derivs_seen  = 0;
    int clipped_seen = 0;
    int ends_seen    = 0;
    int settings_run = 0;

    initial
    begin
        for (int i = 0; i < STORE_DEPTH; i++)
            grid_store[i] = '0;
    end

    // Padded extent of one axis: zero counts as one, oversize is clamped
    function automatic int padded(input int v, input int hi);
        if (v < 1)
            return 3;
        if (v > hi)
            return hi + 2;
        return v + 2;
    endfunction

    // Raster step; a counter past a shrunken size wraps on its next increment
    function automatic void advance(inout int c, inout int r, inout int l,
                                    input int pc, input int pr, input int pl);
        c++;
        if (c >= pc)
        begin
            c = 0;
            r++;
            if (r >= pr)
            begin
                r = 0;
                l++;
                if (l >= pl)
                    l = 0;
            end
        end
    endfunction

    // (prev - 2*centre + next) * 1/h^2 in Q16.16, round half up, clip to 32 bits.
    // Returns {clipped, value}. The scale is split in halves to keep the product
    // inside 64 bits; >>> on a signed value floors.
    function automatic logic [32:0] scale_clip(input logic [31:0] prv,
                                               input logic [31:0] cen,
                                               input logic [31:0] nxt);
        longint s;
        longint hi;
        longint lo;
        longint r;
        s  = longint'($signed(prv)) - 2 * longint'($signed(cen)) + longint'($signed(nxt));
        hi = longint'(cfg_scale[31:16]);
        lo = longint'(cfg_scale[15:0]);
        r  = s * hi + ((s * lo + 64'sd32768) >>> 16);
        if (r > 64'sd2147483647)
            return {1'b1, S32_MAX};
        if (r < -64'sd2147483648)
            return {1'b1, S32_MIN};
        return {1'b0, r[31:0]};
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_W-1:0] value);
        case (idx)
            REG_AXIS_SELECT:    cfg_axis   = value[AXIS_W-1:0];
            REG_INTERIOR_COLS:  cfg_cols   = value[ICOL_W-1:0];
            REG_INTERIOR_ROWS:  cfg_rows   = value[IROW_W-1:0];
            REG_INTERIOR_LAYER: cfg_layers = value[ILAY_W-1:0];
            REG_INV_H_SQUARED:  cfg_scale  = value[SCALE_W-1:0];
            default: ;
        endcase
    endfunction

    // One accepted sample: decide whether it closes a stencil, queue the
    // expected derivative, then store it and move the raster position on.
    function automatic void absorb_sample(input logic [63:0] word);
        int          pc;
        int          pr;
        int          pl;
        int          stride;
        bit          hit;
        bit          at_end;
        logic [63:0] cen_w;
        logic [63:0] prv_w;
        logic [32:0] re_q;
        logic [32:0] im_q;
        deriv_word_t want;
        pc = padded(int'(cfg_cols), MAX_PADDED_COLS - 2);
        pr = padded(int'(cfg_rows), MAX_PADDED_ROWS - 2);
        pl = padded(int'(cfg_layers), 65535);
        hit = 1'b0;
        at_end = 1'b0;
        stride = 0;
        case (cfg_axis)
            AXIS_X:
            begin
                hit = pos_col >= 2 && pos_col <= pc - 1 && pos_row >= 1 && pos_row <= pr - 2
                      && pos_layer >= 1 && pos_layer <= pl - 2;
                at_end = pos_col == pc - 1 && pos_row == pr - 2 && pos_layer == pl - 2;
                stride = 1;
            end
            AXIS_Y:
            begin
                hit = pos_col >= 1 && pos_col <= pc - 2 && pos_row >= 2 && pos_row <= pr - 1
                      && pos_layer >= 1 && pos_layer <= pl - 2;
                at_end = pos_col == pc - 2 && pos_row == pr - 1 && pos_layer == pl - 2;
                stride = pc;
            end
            AXIS_Z:
            begin
                hit = pos_col >= 1 && pos_col <= pc - 2 && pos_row >= 1 && pos_row <= pr - 2
                      && pos_layer >= 2 && pos_layer <= pl - 1;
                at_end = pos_col == pc - 2 && pos_row == pr - 2 && pos_layer == pl - 1;
                stride = pc * pr;
            end
            default: ;
        endcase

        if (hit)
        begin
            cen_w = grid_store[(store_ptr + STORE_DEPTH - stride) % STORE_DEPTH];
            prv_w = grid_store[(store_ptr + STORE_DEPTH - 2 * stride) % STORE_DEPTH];
            re_q = scale_clip(prv_w[31:0], cen_w[31:0], word[31:0]);
            im_q = scale_clip(prv_w[63:32], cen_w[63:32], word[63:32]);
            want.re       = re_q[31:0];
            want.im       = im_q[31:0];
            want.clipped  = re_q[32] | im_q[32];
            want.grid_end = at_end;
            pending_derivs.push_back(want);
        end

        grid_store[store_ptr] = word;
        store_ptr = (store_ptr + 1) % STORE_DEPTH;
        advance(pos_col, pos_row, pos_layer, pc, pr, pl);
    endfunction

    // Samples needed from the current position until the raster wraps to the origin
    function automatic int steps_to_wrap();
        int c;
        int r;
        int l;
        int pc;
        int pr;
        int pl;
        int n;
        c = pos_col;
        r = pos_row;
        l = pos_layer;
        pc = padded(int'(cfg_cols), MAX_PADDED_COLS - 2);
        pr = padded(int'(cfg_rows), MAX_PADDED_ROWS - 2);
        pl = padded(int'(cfg_layers), 65535);
        n = 0;
        while ((c != 0 || r != 0 || l != 0) && n < 100000)
        begin
            advance(c, r, l, pc, pr, pl);
            n++;
        end
        return n;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("MISMATCH @%0t: %s", $time, what);
    endtask

    task automatic check_deriv();
        deriv_word_t want;
        if (pending_derivs.size() == 0)
        begin
            flag_mismatch($sformatf("derivative word %h with nothing pending", m_tdata));
            return;
        end
        want = pending_derivs.pop_front();
        derivs_seen++;
        if (m_tuser)
            clipped_seen++;
        if (m_tlast)
            ends_seen++;
        if (m_tdata[31:0] !== want.re)
            flag_mismatch($sformatf("deriv_re %h, want %h", m_tdata[31:0], want.re));
        if (m_tdata[63:32] !== want.im)
            flag_mismatch($sformatf("deriv_im %h, want %h", m_tdata[63:32], want.im));
        if (m_tuser !== want.clipped)
            flag_mismatch($sformatf("saturated %b, want %b", m_tuser, want.clipped));
        if (m_tlast !== want.grid_end)
            flag_mismatch($sformatf("last_point %b, want %b", m_tlast, want.grid_end));
    endtask

    // ------------------------------------------------------------------------
    // Rising edge: register writes, accepted samples, accepted derivatives
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        in_fire  = rst_n && s_tvalid && s_tready;
        out_fire = rst_n && m_tvalid && m_tready;
        if (rst_n && cfg_write_en)
            apply_reg(cfg_index, cfg_data);
        if (in_fire)
        begin
            absorb_sample(s_tdata);
            samples_taken++;
        end
        if (out_fire)
            check_deriv();
    end

    // ------------------------------------------------------------------------
    // Falling edge: sample driver and result-side ready
    // ------------------------------------------------------------------------
    function automatic int draw_pause();
        if (quiet_pace)
            return 0;
        return $urandom_range(0, 6);
    endfunction

    // A word stays up until taken; each word carries its own gap before the next
    always @(negedge clk)
    begin : drive_samples
        logic        v;
        logic [63:0] d;
        v = s_tvalid;
        d = s_tdata;
        if (!rst_n)
            v = 1'b0;
        else
        begin
            if (in_fire)
                v = 1'b0;
            if (!v)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (sample_backlog.size() > 0)
                begin
                    d = sample_backlog.pop_front();
                    v = 1'b1;
                    gap_left = draw_pause();
                end
            end
        end
        s_tvalid <= v;
        s_tdata  <= d;
    end

    // After each taken result, drop ready for a drawn number of cycles
    always @(negedge clk)
    begin : drive_ready
        logic rdy;
        rdy = m_tready;
        if (!rst_n)
            rdy = 1'b0;
        else if (out_fire)
        begin
            stall_left = draw_pause();
            rdy = (stall_left == 0);
        end
        else if (!rdy)
        begin
            if (stall_left > 0)
                stall_left--;
            rdy = (stall_left == 0);
        end
        m_tready <= rdy;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
    endtask

    task automatic program_grid(input logic [AXIS_W-1:0] axis, input int cols, input int rows,
                                input int layers, input logic [31:0] scale);
        put_reg(REG_AXIS_SELECT, 32'(axis));
        put_reg(REG_INTERIOR_COLS, 32'(cols));
        put_reg(REG_INTERIOR_ROWS, 32'(rows));
        put_reg(REG_INTERIOR_LAYER, 32'(layers));
        put_reg(REG_INV_H_SQUARED, scale);
        @(negedge clk);
        cfg_write_en <= 1'b0;
        settings_run++;
    endtask

    // Wait until every sample is taken and every derivative has come back,
    // then let the pipeline drain (samples that give no word may still be in flight)
    task automatic settle();
        int waited;
        waited = 0;
        while ((samples_taken != samples_queued || pending_derivs.size() != 0)
               && waited < PATIENCE)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic queue_sample(input logic [63:0] word);
        sample_backlog.push_back(word);
        samples_queued++;
    endtask

    function automatic logic [31:0] draw_component();
        case ($urandom_range(0, 7))
            0: return S32_MAX;
            1: return S32_MIN;
            2: return 32'h0;
            3: return 32'hFFFF_FFFF;
            4, 5: return 32'($urandom_range(0, 32'h3FFFF)) - 32'h20000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] draw_scale();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h0001_0000;
            3: return $urandom_range(0, 32'h3FFFF);
            default: return $urandom;
        endcase
    endfunction

    // Bring the raster back to the origin through a small 3x3x3 grid so the
    // next setting starts on a grid boundary; the flush words are checked too.
    task automatic realign();
        int n;
        if (pos_col == 0 && pos_row == 0 && pos_layer == 0)
            return;
        program_grid(2'($urandom_range(0, 3)), 1, 1, 1, draw_scale());
        n = steps_to_wrap();
        for (int i = 0; i < n; i++)
            queue_sample({draw_component(), draw_component()});
        settle();
    endtask

    task automatic run_grid(input logic [AXIS_W-1:0] axis, input int cols, input int rows,
                            input int layers, input logic [31:0] scale, input int count);
        realign();
        program_grid(axis, cols, rows, layers, scale);
        quiet_pace = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < count; i++)
            queue_sample({draw_component(), draw_component()});
        settle();
    endtask

    // Small random grid; mostly whole grids, sometimes cut short
    task automatic run_random_grid();
        logic [AXIS_W-1:0] axis;
        int cols;
        int rows;
        int layers;
        int span;
        axis   = ($urandom_range(0, 7) == 0) ? AXIS_NONE : 2'($urandom_range(0, 2));
        cols   = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
        rows   = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
        layers = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
        span   = padded(cols, MAX_PADDED_COLS - 2) * padded(rows, MAX_PADDED_ROWS - 2)
                 * padded(layers, 65535);
        if ($urandom_range(0, 4) == 0)
            span = $urandom_range(1, span);
        run_grid(axis, cols, rows, layers, draw_scale(), span);
    endtask

    initial
    begin : stimulus
        logic [31:0] re;
        logic [31:0] im;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: one 3x3x3 grid along x with full-range scale. The single
        // interior point sees max/min/max on the real part and the mirror on
        // the imaginary part, so both clip, and it is also the grid's last point.
        program_grid(AXIS_X, 1, 1, 1, 32'hFFFF_FFFF);
        for (int i = 0; i < 27; i++)
        begin
            case (i % 3)
                0: re = 32'h0;
                1: re = 32'hFFFF_FFFF;
                default: re = 32'h0001_0000;
            endcase
            im = ~re;
            if (i == 12 || i == 14)
            begin
                re = S32_MAX;
                im = S32_MIN;
            end
            else if (i == 13)
            begin
                re = S32_MIN;
                im = S32_MAX;
            end
            queue_sample({im, re});
        end
        settle();

        // Oversized columns, zero rows and layers: part of row 1 of layer 1 along x
        run_grid(AXIS_X, 63, 0, 0, 32'h0001_0000, 290);
        run_random_grid();
        // Tallest plane, zero columns, along y
        run_grid(AXIS_Y, 0, 62, 1, draw_scale(), 230);
        run_random_grid();
        // Deepest grid along z with zero scale; left mid-grid on purpose
        run_grid(AXIS_Z, 1, 1, 65535, 32'h0, 60);

        while (samples_queued < TARGET_SAMPLES)
            run_random_grid();

        settle();
        if (samples_taken != samples_queued)
            flag_mismatch($sformatf("%0d of %0d samples never taken",
                                    samples_queued - samples_taken, samples_queued));
        if (pending_derivs.size() != 0)
            flag_mismatch($sformatf("%0d derivative words never arrived", pending_derivs.size()));

        $display("Ran %0d samples through %0d grid settings (x, y, z and no axis).",
                 samples_taken, settings_run);
        $display("Checked %0d derivative words: %0d clipped, %0d grid-end marks.",
                 derivs_seen, clipped_seen, ends_seen);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Hard stop; a correct run ends far sooner
    initial
    begin : watchdog
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
